// File: rtl/core/blw_pkg.sv
// ----------------------------------------------------------------------------
// blw_pkg
// shared types and constants of the breakpoint linear wavetable core
// ----------------------------------------------------------------------------
package blw_pkg;

    // shared divider: dividend and divisor widths
    localparam int DIV_W = 50;
    localparam int DVS_W = 34;

    // request commands
    localparam logic [1:0] CMD_LOAD   = 2'd0;
    localparam logic [1:0] CMD_BUILD  = 2'd1;
    localparam logic [1:0] CMD_READ   = 2'd2;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    // configuration register indexes
    localparam logic [1:0] CFG_SIZE    = 2'd0;
    localparam logic [1:0] CFG_OFFSET  = 2'd1;
    localparam logic [1:0] CFG_RESCALE = 2'd2;

    localparam logic [15:0] DEFAULT_SIZE = 16'd512;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_RD_ADDR,
        S_RD_OUT,
        S_BP0,
        S_BP0_W,
        S_SEG,
        S_LEN_W,
        S_AMP_W,
        S_ELEM,
        S_SDIV,
        S_SWAIT,
        S_SWR,
        S_PK_RD,
        S_PK_W,
        S_NM_RD,
        S_NM_W,
        S_NM_WAIT,
        S_NM_WR
    } t_state;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

// File: rtl/core/breakpoint_linear_wavetable_core.sv
// ----------------------------------------------------------------------------
// breakpoint_linear_wavetable_core
// piecewise-linear wavetable builder with peak rescale and indexed read-out
// ----------------------------------------------------------------------------
// After reset the core sweeps the wave memory to zero, one entry per cycle,
// over all TABLE_DEPTH entries, and takes no request until it is done
// (config writes are taken at any time). A read request passes through an
// address state and an output state and waits in the latter until the
// result register is free. A load request not marked last leaves the core
// ready; a load marked last and a rebuild request walk the breakpoint list
// and the table through one shared restoring divider, one division per
// generated entry; with rescale set, a peak scan follows and each entry is
// divided by a nonzero peak. The core is not ready while it works.
// ----------------------------------------------------------------------------
module breakpoint_linear_wavetable_core #(
    parameter int MAX_POINTS  = 64,
    parameter int TABLE_DEPTH = 32768
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // request channel
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [1:0]         i_cmd,
    input  logic signed [31:0] i_value,
    input  logic               i_last,
    // result channel
    output logic               o_valid,
    input  logic               i_ready,
    output logic [30:0]        o_index,
    output logic signed [31:0] o_amplitude,
    output logic               o_last_entry,
    // configuration write port
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [15:0]        i_cfg_data
);
    import blw_pkg::*;

    localparam int AW   = $clog2(TABLE_DEPTH);
    localparam int NW   = $clog2(TABLE_DEPTH + 1);
    localparam int PW   = $clog2(MAX_POINTS);
    localparam int CW   = $clog2(MAX_POINTS + 1);
    localparam int POSW = CW + 16;

    // state and registers
    t_state r_state, n_state;

    logic [NW-1:0]      r_size;
    logic [15:0]        r_offset;
    logic               r_rescale;

    logic [CW-1:0]      r_lp, n_lp;
    logic [CW-1:0]      r_pc, n_pc;
    logic [AW-1:0]      r_rp, n_rp;
    logic [MAX_POINTS-1:0] r_bp_valid;

    logic [CW-1:0]      r_k, n_k;
    logic [POSW-1:0]    r_pos, n_pos;
    logic [14:0]        r_len, n_len;
    logic [14:0]        r_l, n_l;
    logic signed [31:0] r_amp1, n_amp1;
    logic signed [31:0] r_amp2, n_amp2;
    logic [31:0]        r_adiff, n_adiff;
    logic               r_neg, n_neg;
    logic [46:0]        r_prod, n_prod;
    logic [NW-1:0]      r_j, n_j;
    logic [31:0]        r_peak, n_peak;
    logic               r_olast, n_olast;
    logic [30:0]        r_idx, n_idx;

    logic               r_o_valid, n_o_valid;
    logic [30:0]        r_o_index, n_o_index;
    logic [31:0]        r_o_amp, n_o_amp;
    logic               r_o_last, n_o_last;

    // breakpoint memory
    logic [31:0]        bp_mem [MAX_POINTS];
    logic [31:0]        r_bp_rd;
    logic               r_bp_zero;
    logic [CW-1:0]      bp_raddr;
    logic [31:0]        bp_val;
    logic               bp_we;

    // wave memory
    logic [31:0]        wave_mem [TABLE_DEPTH];
    logic [31:0]        r_wv_rd;
    logic               wv_we;
    logic [AW-1:0]      wv_addr;
    logic [31:0]        wv_wdata;

    // shared divider
    logic               div_start;
    logic [DIV_W-1:0]   div_dividend;
    logic [DVS_W-1:0]   div_divisor;
    logic [DIV_W-1:0]   div_q;
    t_div_stat          div_stat;

    logic               in_acc;
    logic               out_free;
    logic [POSW-1:0]    seg_addr;
    logic               seg_end;
    logic [31:0]        wv_mag;
    logic signed [33:0] seg_q;
    logic signed [33:0] seg_sum;
    logic [31:0]        nm_val;
    logic signed [32:0] amp_diff;
    logic [16:0]        cfg_ext;

    blw_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_quotient (div_q),
        .o_stat     (div_stat)
    );

    assign o_ready  = (r_state == S_IDLE);
    assign in_acc   = i_valid & o_ready;
    assign out_free = !r_o_valid || i_ready;

    // missing or out-of-range breakpoints read as zero
    assign bp_val   = r_bp_zero ? 32'd0 : r_bp_rd;

    assign seg_addr = r_pos + POSW'(r_l);
    assign seg_end  = (r_l == r_len) || (seg_addr >= POSW'(r_size));
    assign wv_mag   = r_wv_rd[31] ? (~r_wv_rd + 32'd1) : r_wv_rd;
    assign seg_q    = r_neg ? -$signed({1'b0, div_q[32:0]}) : $signed({1'b0, div_q[32:0]});
    assign seg_sum  = 34'(r_amp1) + seg_q;
    assign nm_val   = r_neg ? (32'd0 - div_q[31:0]) : div_q[31:0];
    assign amp_diff = 33'($signed(bp_val)) - 33'(r_amp1);
    assign cfg_ext  = {1'b0, i_cfg_data};

    // configuration registers, size clamped on write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size    <= NW'(DEFAULT_SIZE);
            r_offset  <= '0;
            r_rescale <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SIZE: begin
                    if (i_cfg_data == '0) begin
                        r_size <= NW'(1);
                    end else if (cfg_ext > 17'(TABLE_DEPTH)) begin
                        r_size <= NW'(TABLE_DEPTH);
                    end else begin
                        r_size <= NW'(i_cfg_data);
                    end
                end
                CFG_OFFSET:  r_offset  <= i_cfg_data;
                CFG_RESCALE: r_rescale <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (r_j == NW'(TABLE_DEPTH - 1)) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (in_acc) begin
                    case (i_cmd)
                        CMD_LOAD:  n_state = i_last ? S_BP0 : S_IDLE;
                        CMD_BUILD: n_state = S_BP0;
                        CMD_READ:  n_state = S_RD_ADDR;
                        default:   n_state = S_IDLE;
                    endcase
                end
            end
            S_RD_ADDR: n_state = S_RD_OUT;
            S_RD_OUT:  if (out_free) n_state = S_IDLE;
            S_BP0:     n_state = S_BP0_W;
            S_BP0_W:   n_state = S_SEG;
            S_SEG: begin
                if (r_k < r_pc)     n_state = S_LEN_W;
                else if (r_rescale) n_state = S_PK_RD;
                else                n_state = S_IDLE;
            end
            S_LEN_W:   n_state = S_AMP_W;
            S_AMP_W:   n_state = S_ELEM;
            S_ELEM:    n_state = seg_end ? S_SEG : S_SDIV;
            S_SDIV:    n_state = S_SWAIT;
            S_SWAIT:   if (div_stat.done) n_state = S_SWR;
            S_SWR:     n_state = S_ELEM;
            S_PK_RD: begin
                if (r_j == r_size) n_state = (r_peak != '0) ? S_NM_RD : S_IDLE;
                else               n_state = S_PK_W;
            end
            S_PK_W:    n_state = S_PK_RD;
            S_NM_RD:   n_state = (r_j == r_size) ? S_IDLE : S_NM_W;
            S_NM_W:    n_state = S_NM_WAIT;
            S_NM_WAIT: if (div_stat.done) n_state = S_NM_WR;
            S_NM_WR:   n_state = S_NM_RD;
            default:   n_state = S_IDLE;
        endcase
    end

    // datapath and memory controls
    always_comb begin
        n_lp      = r_lp;
        n_pc      = r_pc;
        n_rp      = r_rp;
        n_k       = r_k;
        n_pos     = r_pos;
        n_len     = r_len;
        n_l       = r_l;
        n_amp1    = r_amp1;
        n_amp2    = r_amp2;
        n_adiff   = r_adiff;
        n_neg     = r_neg;
        n_prod    = r_prod;
        n_j       = r_j;
        n_peak    = r_peak;
        n_olast   = r_olast;
        n_idx     = r_idx;
        n_o_valid = r_o_valid && !i_ready;
        n_o_index = r_o_index;
        n_o_amp   = r_o_amp;
        n_o_last  = r_o_last;

        bp_we        = 1'b0;
        bp_raddr     = '0;
        wv_we        = 1'b0;
        wv_addr      = r_rp;
        wv_wdata     = '0;
        div_start    = 1'b0;
        div_dividend = DIV_W'({r_prod, 1'b0}) + DIV_W'(r_len);
        div_divisor  = DVS_W'({r_len, 1'b0});

        case (r_state)
            S_CLEAR: begin
                wv_we   = 1'b1;
                wv_addr = r_j[AW-1:0];
                n_j     = r_j + 1'b1;
            end
            S_IDLE: begin
                if (in_acc) begin
                    case (i_cmd)
                        CMD_LOAD: begin
                            if (r_lp < CW'(MAX_POINTS)) begin
                                bp_we = 1'b1;
                                n_lp  = r_lp + 1'b1;
                            end
                            if (i_last) begin
                                n_pc = (r_lp < CW'(MAX_POINTS)) ? r_lp + 1'b1 : r_lp;
                                n_lp = '0;
                                n_rp = '0;
                            end
                        end
                        CMD_BUILD: n_rp = '0;
                        CMD_READ: begin
                            // pointer left past a shrunken size restarts
                            if (NW'(r_rp) >= r_size) n_rp = '0;
                        end
                        default: ;
                    endcase
                end
            end
            S_RD_ADDR: begin
                wv_addr = r_rp;
                n_idx   = 31'(r_rp) + 31'(r_offset) * 31'(r_size);
                n_olast = (NW'(r_rp) == r_size - 1'b1);
            end
            S_RD_OUT: begin
                wv_addr = r_rp;
                if (out_free) begin
                    n_o_valid = 1'b1;
                    n_o_index = r_idx;
                    n_o_amp   = r_wv_rd;
                    n_o_last  = r_olast;
                    n_rp      = r_olast ? '0 : r_rp + 1'b1;
                end
            end
            S_BP0: bp_raddr = '0;
            S_BP0_W: begin
                n_amp2 = bp_val;
                n_k    = CW'(1);
                n_pos  = '0;
            end
            S_SEG: begin
                bp_raddr = r_k;
                n_j      = '0;
                n_peak   = '0;
            end
            S_LEN_W: begin
                // negative length counts as zero, integer part otherwise
                n_len    = bp_val[31] ? 15'd0 : bp_val[30:16];
                n_amp1   = r_amp2;
                bp_raddr = r_k + 1'b1;
            end
            S_AMP_W: begin
                n_amp2  = bp_val;
                n_neg   = amp_diff[32];
                n_adiff = amp_diff[32] ? 32'(-amp_diff) : amp_diff[31:0];
                n_l     = '0;
            end
            S_ELEM: begin
                if (seg_end) begin
                    n_pos = r_pos + POSW'(r_len);
                    n_k   = r_k + CW'(2);
                end else begin
                    n_prod = r_adiff * r_l;
                end
            end
            S_SDIV: div_start = 1'b1;
            S_SWR: begin
                wv_we    = 1'b1;
                wv_addr  = seg_addr[AW-1:0];
                wv_wdata = seg_sum[31:0];
                n_l      = r_l + 1'b1;
            end
            S_PK_RD: begin
                wv_addr = r_j[AW-1:0];
                if (r_j == r_size) n_j = '0;
            end
            S_PK_W: begin
                if (wv_mag > r_peak) n_peak = wv_mag;
                n_j = r_j + 1'b1;
            end
            S_NM_RD: wv_addr = r_j[AW-1:0];
            S_NM_W: begin
                wv_addr      = r_j[AW-1:0];
                n_neg        = r_wv_rd[31];
                div_start    = 1'b1;
                div_dividend = DIV_W'({wv_mag, 17'd0}) + DIV_W'(r_peak);
                div_divisor  = DVS_W'({r_peak, 1'b0});
            end
            S_NM_WR: begin
                wv_we    = 1'b1;
                wv_addr  = r_j[AW-1:0];
                wv_wdata = nm_val;
                n_j      = r_j + 1'b1;
            end
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_lp       <= '0;
            r_pc       <= '0;
            r_rp       <= '0;
            r_j        <= '0;
            r_o_valid  <= 1'b0;
            r_bp_valid <= '0;
        end else begin
            r_state   <= n_state;
            r_lp      <= n_lp;
            r_pc      <= n_pc;
            r_rp      <= n_rp;
            r_j       <= n_j;
            r_o_valid <= n_o_valid;
            if (bp_we) r_bp_valid[r_lp[PW-1:0]] <= 1'b1;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_k       <= n_k;
        r_pos     <= n_pos;
        r_len     <= n_len;
        r_l       <= n_l;
        r_amp1    <= n_amp1;
        r_amp2    <= n_amp2;
        r_adiff   <= n_adiff;
        r_neg     <= n_neg;
        r_prod    <= n_prod;
        r_peak    <= n_peak;
        r_olast   <= n_olast;
        r_idx     <= n_idx;
        r_o_index <= n_o_index;
        r_o_amp   <= n_o_amp;
        r_o_last  <= n_o_last;
    end

    // breakpoint memory, registered read
    always_ff @(posedge i_clk) begin
        if (bp_we) bp_mem[r_lp[PW-1:0]] <= i_value;
        r_bp_rd   <= bp_mem[bp_raddr[PW-1:0]];
        r_bp_zero <= (bp_raddr >= CW'(MAX_POINTS)) || !r_bp_valid[bp_raddr[PW-1:0]];
    end

    // wave memory, single port, registered read
    always_ff @(posedge i_clk) begin
        if (wv_we) wave_mem[wv_addr] <= wv_wdata;
        r_wv_rd <= wave_mem[wv_addr];
    end

    assign o_valid      = r_o_valid;
    assign o_index      = r_o_index;
    assign o_amplitude  = r_o_amp;
    assign o_last_entry = r_o_last;

    // load pointer saturates at the list capacity
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_lp <= CW'(MAX_POINTS))
        else $error("load pointer past list capacity");

    // segment writes stay inside the active table
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SWR) |-> (seg_addr < POSW'(r_size)))
        else $error("segment write beyond table size");

    // divider is never restarted while it runs
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |-> !div_stat.busy)
        else $error("divider restarted while busy");

    // rescaled entries never exceed unity
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_NM_WR) |-> (div_q <= DIV_W'(65536)))
        else $error("rescaled entry above unity");

endmodule

// File: rtl/core/blw_div.sv
// ----------------------------------------------------------------------------
// blw_div
// restoring unsigned divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module blw_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [blw_pkg::DIV_W-1:0]  i_dividend,
    input  logic [blw_pkg::DVS_W-1:0]  i_divisor,
    output logic [blw_pkg::DIV_W-1:0]  o_quotient,
    output blw_pkg::t_div_stat         o_stat
);
    import blw_pkg::*;

    localparam int CNW = $clog2(DIV_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNW-1:0]   r_cnt;
    logic [DVS_W-1:0] r_rem;
    logic [DVS_W-1:0] r_dvs;
    logic [DIV_W-1:0] r_quo;

    logic [DVS_W:0]   trial;
    logic             fits;
    logic [DVS_W:0]   diff;

    always_comb begin
        trial = {r_rem, r_quo[DIV_W-1]};
        fits  = (trial >= {1'b0, r_dvs});
        diff  = trial - {1'b0, r_dvs};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNW'(DIV_W - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_dvs <= i_divisor;
            r_quo <= i_dividend;
        end else if (r_busy) begin
            r_rem <= fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
            r_quo <= {r_quo[DIV_W-2:0], fits};
        end
    end

    assign o_quotient  = r_quo;
    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;

endmodule
